@@ src/rrot_pkg.sv @@
// Shared types, constants and helpers for the readout reference offset tracker.
`timescale 1ns / 1ps
package rrot_pkg;

   localparam int SETPOINTS       = 4;
   localparam int RADIAL_BTN_BASE = 0;
   localparam int AXIAL_BTN_BASE  = 4;
   localparam int TOGGLE_BTN_BIT  = 8;

   localparam int AXES      = 2;
   localparam int AX_AXIAL  = 0;
   localparam int AX_RADIAL = 1;

   localparam int POS_W  = 32;
   localparam int BTN_W  = 16;
   localparam int REQ_DATA_W = 120;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 104;

   typedef logic [2:0] opcode_type;

   localparam opcode_type OP_SAMPLE    = 3'd0;
   localparam opcode_type OP_BUTTONS   = 3'd1;
   localparam opcode_type OP_ZERO_MAIN = 3'd2;
   localparam opcode_type OP_PRESET    = 3'd3;
   localparam opcode_type OP_ZERO_SP   = 3'd4;
   localparam opcode_type OP_TOGGLE    = 3'd5;

   typedef struct packed {
      opcode_type        opcode;
      logic [POS_W-1:0]  axial_pos;
      logic [POS_W-1:0]  radial_pos;
      logic [BTN_W-1:0]  button_word;
      logic              axis_sel;
      logic [2:0]        slot;
      logic [POS_W-1:0]  preset_counts;
      logic              query_axis;
      logic [1:0]        query_slot;
   } req_item_type;

   typedef struct packed {
      logic [POS_W-1:0]  axial_main_delta;
      logic [POS_W-1:0]  radial_main_delta;
      logic [POS_W-1:0]  query_delta;
      logic              query_active;
      logic              radius_mode_out;
   } rsp_item_type;

   // rising edge at a button bit; bits past the word never fire
   function automatic logic btn_edge(input logic [BTN_W-1:0] edges, input int bit_idx);
      logic hit;
      hit = 1'b0;
      if (bit_idx >= 0 && bit_idx < BTN_W) begin
         hit = edges[bit_idx[3:0]];
      end
      return hit;
   endfunction

endpackage

@@ src/readout_reference_offset_tracker.sv @@
// Top level: stream ports, input register and result register around the tracker core.
`timescale 1ns / 1ps
// Two-axis readout tracker. Every request beat yields exactly one response beat
// carrying both main deltas, the queried setpoint delta and active flag, and the
// radius mode, all as they stand after that beat's update. A beat passes through
// one input register and one result register; one beat per cycle is sustained
// while the output is not stalled, bounded only by the single-pass update between
// the two registers. Deltas are stored values: a preset leaves setpoint deltas
// stale until the next sample.
module readout_reference_offset_tracker
   import rrot_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // axial_pos, radial_pos, button_word, axis_sel, slot, preset_counts,
   // query_axis, query_slot, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // axial_main_delta, radial_main_delta, query_delta, query_active,
   // radius_mode_out, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   req_item_type req_item_ff;
   req_item_type req_item_in;
   logic         req_valid_ff;
   logic         req_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   rsp_item_type result;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         advance;
   logic         req_take;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      req_item_in.opcode        = req_tuser;
      req_item_in.axial_pos     = req_tdata[31:0];
      req_item_in.radial_pos    = req_tdata[63:32];
      req_item_in.button_word   = req_tdata[79:64];
      req_item_in.axis_sel      = req_tdata[80];
      req_item_in.slot          = req_tdata[83:81];
      req_item_in.preset_counts = req_tdata[115:84];
      req_item_in.query_axis    = req_tdata[116];
      req_item_in.query_slot    = req_tdata[118:117];
   end

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign rsp_item_in  = result;

   rrot_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_item_in;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_item_type)){1'b0}},
                        rsp_item_ff.radius_mode_out,
                        rsp_item_ff.query_active,
                        rsp_item_ff.query_delta,
                        rsp_item_ff.radial_main_delta,
                        rsp_item_ff.axial_main_delta};

endmodule

@@ src/rrot_core.sv @@
// Tracker state and the single-pass update for one beat.
`timescale 1ns / 1ps
module rrot_core
   import rrot_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [POS_W-1:0] raw_ff       [AXES];
   logic [POS_W-1:0] raw_in       [AXES];
   logic [POS_W-1:0] main_ref_ff  [AXES];
   logic [POS_W-1:0] main_ref_in  [AXES];
   logic [POS_W-1:0] main_dlt_ff  [AXES];
   logic [POS_W-1:0] main_dlt_in  [AXES];
   logic [POS_W-1:0] sp_ref_ff    [AXES][SETPOINTS];
   logic [POS_W-1:0] sp_ref_in    [AXES][SETPOINTS];
   logic [POS_W-1:0] sp_dlt_ff    [AXES][SETPOINTS];
   logic [POS_W-1:0] sp_dlt_in    [AXES][SETPOINTS];
   logic             sp_act_ff    [AXES][SETPOINTS];
   logic             sp_act_in    [AXES][SETPOINTS];
   logic             radius_ff;
   logic             radius_in;
   logic [BTN_W-1:0] prev_btn_ff;
   logic [BTN_W-1:0] prev_btn_in;

   logic [BTN_W-1:0] edges;
   logic [POS_W:0]   preset_rnd;
   logic [POS_W-1:0] preset_pos;
   logic [POS_W-1:0] zm_shift;
   logic [POS_W-1:0] pr_shift;

   assign edges      = item.button_word & ~prev_btn_ff;
   // halve toward zero: add one to negatives before the shift
   assign preset_rnd = {item.preset_counts[POS_W-1], item.preset_counts}
                       + {{POS_W{1'b0}}, item.preset_counts[POS_W-1]};
   assign preset_pos = radius_ff ? preset_rnd[POS_W:1] : item.preset_counts;
   assign zm_shift   = raw_ff[item.axis_sel] - main_ref_ff[item.axis_sel];
   assign pr_shift   = preset_pos - main_ref_ff[AX_RADIAL];

   always_comb begin
      raw_in      = raw_ff;
      main_ref_in = main_ref_ff;
      main_dlt_in = main_dlt_ff;
      sp_ref_in   = sp_ref_ff;
      sp_dlt_in   = sp_dlt_ff;
      sp_act_in   = sp_act_ff;
      radius_in   = radius_ff;
      prev_btn_in = prev_btn_ff;
      if (advance) begin
         unique case (item.opcode)
            OP_SAMPLE: begin
               raw_in[AX_AXIAL]  = item.axial_pos;
               raw_in[AX_RADIAL] = item.radial_pos;
               for (int a = 0; a < AXES; a++) begin
                  main_dlt_in[a] = raw_in[a] - main_ref_ff[a];
                  for (int i = 0; i < SETPOINTS; i++) begin
                     if (sp_act_ff[a][i]) begin
                        sp_dlt_in[a][i] = raw_in[a] - sp_ref_ff[a][i];
                     end
                  end
               end
            end
            OP_BUTTONS: begin
               prev_btn_in = item.button_word;
               for (int i = 0; i < SETPOINTS; i++) begin
                  if (btn_edge(edges, RADIAL_BTN_BASE + i)) begin
                     sp_ref_in[AX_RADIAL][i] = raw_ff[AX_RADIAL];
                     sp_dlt_in[AX_RADIAL][i] = '0;
                     sp_act_in[AX_RADIAL][i] = 1'b1;
                  end
                  if (btn_edge(edges, AXIAL_BTN_BASE + i)) begin
                     sp_ref_in[AX_AXIAL][i] = raw_ff[AX_AXIAL];
                     sp_dlt_in[AX_AXIAL][i] = '0;
                     sp_act_in[AX_AXIAL][i] = 1'b1;
                  end
               end
               if (btn_edge(edges, TOGGLE_BTN_BIT)) begin
                  radius_in = ~radius_ff;
               end
            end
            OP_ZERO_MAIN: begin
               main_ref_in[item.axis_sel] = raw_ff[item.axis_sel];
               main_dlt_in[item.axis_sel] = '0;
               for (int i = 0; i < SETPOINTS; i++) begin
                  if (sp_act_ff[item.axis_sel][i]) begin
                     sp_ref_in[item.axis_sel][i] = sp_ref_ff[item.axis_sel][i] + zm_shift;
                     // cur - (ref + cur - main) reduces to main - ref
                     sp_dlt_in[item.axis_sel][i] = main_ref_ff[item.axis_sel]
                                                   - sp_ref_ff[item.axis_sel][i];
                  end
               end
            end
            OP_PRESET: begin
               main_ref_in[AX_RADIAL] = preset_pos;
               main_dlt_in[AX_RADIAL] = '0;
               for (int i = 0; i < SETPOINTS; i++) begin
                  if (sp_act_ff[AX_RADIAL][i]) begin
                     sp_ref_in[AX_RADIAL][i] = sp_ref_ff[AX_RADIAL][i] + pr_shift;
                  end
               end
            end
            OP_ZERO_SP: begin
               for (int i = 0; i < SETPOINTS; i++) begin
                  if (int'(item.slot) == i) begin
                     sp_ref_in[item.axis_sel][i] = raw_ff[item.axis_sel];
                     sp_dlt_in[item.axis_sel][i] = '0;
                     sp_act_in[item.axis_sel][i] = 1'b1;
                  end
               end
            end
            OP_TOGGLE: begin
               radius_in = ~radius_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // result reflects the state after this beat
   always_comb begin
      result.axial_main_delta  = main_dlt_in[AX_AXIAL];
      result.radial_main_delta = main_dlt_in[AX_RADIAL];
      result.query_delta       = '0;
      result.query_active      = 1'b0;
      result.radius_mode_out   = radius_in;
      for (int i = 0; i < SETPOINTS; i++) begin
         if (int'(item.query_slot) == i) begin
            result.query_delta  = sp_dlt_in[item.query_axis][i];
            result.query_active = sp_act_in[item.query_axis][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            raw_ff[a]      <= '0;
            main_ref_ff[a] <= '0;
            main_dlt_ff[a] <= '0;
            for (int i = 0; i < SETPOINTS; i++) begin
               sp_ref_ff[a][i] <= '0;
               sp_dlt_ff[a][i] <= '0;
               sp_act_ff[a][i] <= 1'b0;
            end
         end
         radius_ff   <= 1'b1;
         prev_btn_ff <= '0;
      end else begin
         raw_ff      <= raw_in;
         main_ref_ff <= main_ref_in;
         main_dlt_ff <= main_dlt_in;
         sp_ref_ff   <= sp_ref_in;
         sp_dlt_ff   <= sp_dlt_in;
         sp_act_ff   <= sp_act_in;
         radius_ff   <= radius_in;
         prev_btn_ff <= prev_btn_in;
      end
   end

endmodule

@@ src/rrot_checker.sv @@
// Port-level assertions for the tracker, bound to the top level.
`timescale 1ns / 1ps
module rrot_checker
   import rrot_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without output backpressure");

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[96] |-> rsp_tdata[95:64] == '0)
      else $error("inactive setpoint reports nonzero delta");

endmodule

bind readout_reference_offset_tracker rrot_checker u_rrot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ sim/tb.sv @@
// Self-checking testbench for the readout reference offset tracker stream block.
`timescale 1ns / 1ps
module tb;
   import rrot_pkg::*;

   localparam opcode_type OP_SPARE6 = 3'd6;
   localparam opcode_type OP_SPARE7 = 3'd7;
   localparam int SP_SLOTS     = 8;
   localparam int RANDOM_ITEMS = 1725;
   localparam int CALM_ITEMS   = 200;
   localparam int HOLD_AFTER   = 700;
   localparam int HOLD_SPAN    = 400;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct {
      req_item_type cmd;
      bit           pinned;
      rsp_item_type want;
   } plan_entry_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // tracker state as predicted
   logic [POS_W-1:0] pos_raw  [AXES];
   logic [POS_W-1:0] main_ref [AXES];
   logic [POS_W-1:0] main_dlt [AXES];
   logic [POS_W-1:0] sp_ref   [AXES][SP_SLOTS];
   logic [POS_W-1:0] sp_dlt   [AXES][SP_SLOTS];
   logic             sp_on    [AXES][SP_SLOTS];
   logic             radius_on;
   logic [BTN_W-1:0] btn_prev;

   rsp_item_type due_readouts[$];
   int           fail_count;
   int           accepted_count;
   int           total_items;
   int           cycle_count;

   readout_reference_offset_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic void pin_setpoint(input int ax, input int idx);
      if (idx < SETPOINTS) begin
         sp_ref[ax][idx] = pos_raw[ax];
         sp_dlt[ax][idx] = '0;
         sp_on[ax][idx]  = 1'b1;
      end
   endfunction

   function automatic rsp_item_type advance_tracker(input req_item_type c);
      rsp_item_type     r;
      logic [BTN_W-1:0] rises;
      logic [POS_W-1:0] shift;
      logic [POS_W-1:0] target;
      int               ax;
      int               v;
      ax = c.axis_sel;
      case (c.opcode)
         OP_SAMPLE: begin
            pos_raw[AX_AXIAL]  = c.axial_pos;
            pos_raw[AX_RADIAL] = c.radial_pos;
            for (int a = 0; a < AXES; a++) begin
               main_dlt[a] = pos_raw[a] - main_ref[a];
               for (int i = 0; i < SETPOINTS; i++)
                  if (sp_on[a][i]) sp_dlt[a][i] = pos_raw[a] - sp_ref[a][i];
            end
         end
         OP_BUTTONS: begin
            rises    = c.button_word & ~btn_prev;
            btn_prev = c.button_word;
            for (int i = 0; i < SETPOINTS; i++) begin
               if (RADIAL_BTN_BASE + i < BTN_W && rises[RADIAL_BTN_BASE + i])
                  pin_setpoint(AX_RADIAL, i);
               if (AXIAL_BTN_BASE + i < BTN_W && rises[AXIAL_BTN_BASE + i])
                  pin_setpoint(AX_AXIAL, i);
            end
            if (rises[TOGGLE_BTN_BIT]) radius_on = ~radius_on;
         end
         OP_ZERO_MAIN: begin
            shift        = pos_raw[ax] - main_ref[ax];
            main_ref[ax] = pos_raw[ax];
            main_dlt[ax] = '0;
            for (int i = 0; i < SETPOINTS; i++) begin
               if (sp_on[ax][i]) begin
                  sp_ref[ax][i] = sp_ref[ax][i] + shift;
                  sp_dlt[ax][i] = pos_raw[ax] - sp_ref[ax][i];
               end
            end
         end
         OP_PRESET: begin
            v = $signed(c.preset_counts);
            if (radius_on) v = v / 2;
            target              = v;
            shift               = target - main_ref[AX_RADIAL];
            main_ref[AX_RADIAL] = target;
            main_dlt[AX_RADIAL] = '0;
            // setpoint deltas go stale here on purpose
            for (int i = 0; i < SETPOINTS; i++)
               if (sp_on[AX_RADIAL][i]) sp_ref[AX_RADIAL][i] = sp_ref[AX_RADIAL][i] + shift;
         end
         OP_ZERO_SP: pin_setpoint(ax, c.slot);
         OP_TOGGLE:  radius_on = ~radius_on;
         default: ;
      endcase
      r.axial_main_delta  = main_dlt[AX_AXIAL];
      r.radial_main_delta = main_dlt[AX_RADIAL];
      if (c.query_slot < SETPOINTS) begin
         r.query_delta  = sp_dlt[c.query_axis][c.query_slot];
         r.query_active = sp_on[c.query_axis][c.query_slot];
      end else begin
         r.query_delta  = '0;
         r.query_active = 1'b0;
      end
      r.radius_mode_out = radius_on;
      return r;
   endfunction

   function automatic plan_entry_type row(input opcode_type op, input logic [31:0] ax,
                                          input logic [31:0] rd, input logic [15:0] btn,
                                          input logic sel, input logic [2:0] sl,
                                          input logic [31:0] pre, input logic qa,
                                          input logic [1:0] qs);
      plan_entry_type e;
      e.cmd.opcode        = op;
      e.cmd.axial_pos     = ax;
      e.cmd.radial_pos    = rd;
      e.cmd.button_word   = btn;
      e.cmd.axis_sel      = sel;
      e.cmd.slot          = sl;
      e.cmd.preset_counts = pre;
      e.cmd.query_axis    = qa;
      e.cmd.query_slot    = qs;
      e.pinned            = 1'b0;
      e.want              = '0;
      return e;
   endfunction

   function automatic plan_entry_type pin(input plan_entry_type e, input logic [31:0] ax_d,
                                          input logic [31:0] rd_d, input logic [31:0] q_d,
                                          input logic act, input logic rad);
      plan_entry_type p;
      p                        = e;
      p.pinned                 = 1'b1;
      p.want.axial_main_delta  = ax_d;
      p.want.radial_main_delta = rd_d;
      p.want.query_delta       = q_d;
      p.want.query_active      = act;
      p.want.radius_mode_out   = rad;
      return p;
   endfunction

   function automatic logic [31:0] corner_value();
      logic [31:0] x;
      case ($urandom_range(0, 3))
         0:       x = 32'h0000_0000;
         1:       x = 32'h7FFF_FFFF;
         2:       x = 32'h8000_0000;
         default: x = 32'hFFFF_FFFF;
      endcase
      return x;
   endfunction

   function automatic req_item_type roll_command();
      req_item_type c;
      int           pick;
      int           flavor;
      c.axial_pos     = $urandom;
      c.radial_pos    = $urandom;
      c.button_word   = $urandom;
      c.axis_sel      = $urandom;
      c.slot          = $urandom;
      c.preset_counts = $urandom;
      c.query_axis    = $urandom;
      c.query_slot    = $urandom;
      pick   = $urandom_range(0, 99);
      flavor = $urandom_range(0, 9);
      if (pick < 34) begin
         c.opcode = OP_SAMPLE;
         if (flavor == 0) begin
            c.axial_pos  = corner_value();
            c.radial_pos = corner_value();
         end else if (flavor < 6) begin
            c.axial_pos  = pos_raw[AX_AXIAL] + 32'($urandom_range(0, 4000)) - 32'd2000;
            c.radial_pos = pos_raw[AX_RADIAL] + 32'($urandom_range(0, 4000)) - 32'd2000;
         end
      end else if (pick < 52) begin
         c.opcode = OP_BUTTONS;
         if (flavor < 6) c.button_word = btn_prev ^ (16'd1 << $urandom_range(0, 15));
      end else if (pick < 62) begin
         c.opcode = OP_ZERO_MAIN;
      end else if (pick < 76) begin
         c.opcode = OP_PRESET;
         if (flavor == 0) c.preset_counts = corner_value();
         else if (flavor < 4) c.preset_counts = 32'($urandom_range(0, 2000)) - 32'd1000;
      end else if (pick < 88) begin
         c.opcode = OP_ZERO_SP;
      end else if (pick < 94) begin
         c.opcode = OP_TOGGLE;
      end else begin
         c.opcode = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
      end
      return c;
   endfunction

   task automatic offer_command(input req_item_type c, input bit pinned,
                                input rsp_item_type pinned_val);
      rsp_item_type forecast;
      req_tuser  = c.opcode;
      req_tdata  = {1'b0, c.query_slot, c.query_axis, c.preset_counts, c.slot, c.axis_sel,
                    c.button_word, c.radial_pos, c.axial_pos};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      forecast = advance_tracker(c);
      due_readouts.push_back(pinned ? pinned_val : forecast);
      accepted_count++;
      @(negedge clock);
      if (accepted_count < total_items - CALM_ITEMS && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", label, want, got);
         fail_count++;
      end
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      int  held;
      bit  hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && accepted_count >= HOLD_AFTER) begin
            hold_done  = 1'b1;
            rsp_tready = 1'b0;
            held       = 0;
            while (held < HOLD_SPAN) begin
               @(negedge clock);
               held++;
            end
         end else if (accepted_count < total_items - CALM_ITEMS &&
                      $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.axial_main_delta  = rsp_tdata[31:0];
         seen.radial_main_delta = rsp_tdata[63:32];
         seen.query_delta       = rsp_tdata[95:64];
         seen.query_active      = rsp_tdata[96];
         seen.radius_mode_out   = rsp_tdata[97];
         if (due_readouts.size() == 0) begin
            $error("response beat with no readout outstanding");
            fail_count++;
         end else begin
            want = due_readouts.pop_front();
            check_field("axial_main_delta", want.axial_main_delta, seen.axial_main_delta);
            check_field("radial_main_delta", want.radial_main_delta, seen.radial_main_delta);
            check_field("query_delta", want.query_delta, seen.query_delta);
            check_field("query_active", 32'(want.query_active), 32'(seen.query_active));
            check_field("radius_mode_out", 32'(want.radius_mode_out),
                        32'(seen.radius_mode_out));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("readout_reference_offset_tracker verification failed");
         $finish;
      end
   end

   initial begin
      plan_entry_type plan[$];
      rsp_item_type   no_pin;
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      fail_count     = 0;
      accepted_count = 0;
      cycle_count    = 0;
      no_pin         = '0;
      for (int a = 0; a < AXES; a++) begin
         pos_raw[a]  = '0;
         main_ref[a] = '0;
         main_dlt[a] = '0;
         for (int i = 0; i < SP_SLOTS; i++) begin
            sp_ref[a][i] = '0;
            sp_dlt[a][i] = '0;
            sp_on[a][i]  = 1'b0;
         end
      end
      radius_on = 1'b1;
      btn_prev  = '0;

      // after reset, extremes, then each opcode and the corner cases
      plan.push_back(pin(row(OP_SPARE6, 32'h1234, 32'h5678, 16'hFFFF, 1, 7, 32'h7FFF_FFFF,
                             0, 0), 0, 0, 0, 0, 1));
      plan.push_back(pin(row(OP_SPARE7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 7,
                             32'hFFFF_FFFF, 1, 3), 0, 0, 0, 0, 1));
      plan.push_back(pin(row(OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0),
                         32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1));
      plan.push_back(pin(row(OP_BUTTONS, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0),
                         32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 0));
      plan.push_back(row(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 2));
      plan.push_back(row(OP_ZERO_MAIN, 0, 0, 0, 0, 0, 0, 0, 1));
      plan.push_back(row(OP_ZERO_MAIN, 0, 0, 0, 1, 0, 0, 1, 0));
      plan.push_back(row(OP_PRESET, 0, 0, 0, 0, 0, 32'h8000_0000, 1, 1));
      plan.push_back(row(OP_TOGGLE, 0, 0, 0, 0, 0, 0, 1, 1));
      plan.push_back(row(OP_PRESET, 0, 0, 0, 0, 0, 32'h8000_0000, 1, 2));
      plan.push_back(row(OP_PRESET, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 3));
      plan.push_back(row(OP_PRESET, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, 0));
      plan.push_back(row(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 1, 0));
      plan.push_back(row(OP_BUTTONS, 0, 0, 16'h0000, 0, 0, 0, 0, 2));
      plan.push_back(row(OP_ZERO_SP, 0, 0, 0, 1, 3, 0, 1, 3));
      plan.push_back(row(OP_ZERO_SP, 0, 0, 0, 0, 7, 0, 0, 3));
      plan.push_back(row(OP_ZERO_SP, 0, 0, 0, 1, 4, 0, 1, 0));
      plan.push_back(row(OP_BUTTONS, 0, 0, 16'h0100, 0, 0, 0, 0, 0));
      plan.push_back(row(OP_BUTTONS, 0, 0, 16'h0100, 0, 0, 0, 0, 1));
      plan.push_back(row(OP_BUTTONS, 0, 0, 16'hFEFF, 0, 0, 0, 0, 3));
      plan.push_back(row(OP_SAMPLE, 32'hFFFF_FFFF, 32'h1, 0, 0, 0, 0, 1, 1));
      plan.push_back(row(OP_PRESET, 0, 0, 0, 0, 0, 32'h1, 1, 1));
      plan.push_back(row(OP_TOGGLE, 0, 0, 0, 0, 0, 0, 1, 2));
      plan.push_back(row(OP_PRESET, 0, 0, 0, 0, 0, 32'hFFFF_FFFD, 1, 2));
      plan.push_back(row(OP_SAMPLE, 32'h5, 32'hFFFF_FFF0, 0, 0, 0, 0, 1, 3));
      total_items = plan.size() + RANDOM_ITEMS;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[k]) offer_command(plan[k].cmd, plan[k].pinned, plan[k].want);
      repeat (RANDOM_ITEMS) offer_command(roll_command(), 1'b0, no_pin);
      req_tvalid = 1'b0;

      while (due_readouts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("readout_reference_offset_tracker verification clean");
      end else begin
         $display("readout_reference_offset_tracker verification failed");
      end
      $finish;
   end

endmodule
